@@ rtl/core/gcfp_pkg.sv @@
`timescale 1ns / 1ps
package gcfp_pkg;

    localparam int unsigned LEVEL_W  = 3;
    localparam int unsigned PIXEL_W  = 8;
    localparam int unsigned OUT_W    = 6;
    localparam int unsigned K_W      = 5;
    localparam int unsigned RECIP_W  = 25;
    localparam int unsigned INV_W    = 17;

    localparam logic [31:0] ONE_FX     = 32'd65536;
    localparam logic [31:0] LN2_FX     = 32'd45426;
    localparam logic [K_W-1:0] SERIES_TERMS = 5'd20;
    localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;
    localparam logic [OUT_W-1:0] OUT_MAX = 6'd63;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DOUBLE,
        OP_LN_INIT,
        OP_LN_DIV,
        OP_LN_ACC,
        OP_SCALE_Y,
        OP_EXP_INIT,
        OP_EXP_DIV,
        OP_EXP_MUL,
        OP_EXP_ACC,
        OP_LOAD_OUT
    } t_op;

    typedef struct packed {
        t_op            op;
        logic [K_W-1:0] k;
    } t_cmd;

    typedef struct packed {
        logic x_zero;
        logic x_ge_one;
        logic term_zero;
    } t_status;

    // ceil(2^24 / k): exact quotient for dividends below 2^19
    function automatic logic [RECIP_W-1:0] recip(input logic [K_W-1:0] k);
        logic [RECIP_W-1:0] m;
        unique case (k)
            5'd1:    m = 25'd16777216;
            5'd2:    m = 25'd8388608;
            5'd3:    m = 25'd5592406;
            5'd4:    m = 25'd4194304;
            5'd5:    m = 25'd3355444;
            5'd6:    m = 25'd2796203;
            5'd7:    m = 25'd2396746;
            5'd8:    m = 25'd2097152;
            5'd9:    m = 25'd1864136;
            5'd10:   m = 25'd1677722;
            5'd11:   m = 25'd1525202;
            5'd12:   m = 25'd1398102;
            5'd13:   m = 25'd1290556;
            5'd14:   m = 25'd1198373;
            5'd15:   m = 25'd1118482;
            5'd16:   m = 25'd1048576;
            5'd17:   m = 25'd986896;
            5'd18:   m = 25'd932068;
            5'd19:   m = 25'd883012;
            5'd20:   m = 25'd838861;
            default: m = 25'd0;
        endcase
        return m;
    endfunction

    // 1/gamma in 16.16; levels above 4 saturate
    function automatic logic [INV_W-1:0] gamma_recip(input logic [LEVEL_W-1:0] lvl);
        logic [INV_W-1:0] v;
        unique case (lvl)
            3'd0:    v = 17'd65536;
            3'd1:    v = 17'd56988;
            3'd2:    v = 17'd48544;
            3'd3:    v = 17'd40454;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/gcfp_if.sv @@
`timescale 1ns / 1ps
interface gcfp_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_level;

    modport source (output valid, output pixel_level, input ready);
    modport sink   (input valid, input pixel_level, output ready);
endinterface

interface gcfp_level_if;
    logic       valid;
    logic       ready;
    logic [5:0] corrected_level;

    modport source (output valid, output corrected_level, input ready);
    modport sink   (input valid, input corrected_level, output ready);
endinterface

@@ rtl/core/gcfp_datapath.sv @@
`timescale 1ns / 1ps
module gcfp_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_data,
    input  logic [7:0]               i_pixel_level,
    input  gcfp_pkg::t_cmd           i_cmd,
    output gcfp_pkg::t_status        o_status,
    output logic [5:0]               o_corrected_level
);
    import gcfp_pkg::*;

    logic [LEVEL_W-1:0] r_level;
    logic [16:0]        r_x;
    logic [15:0]        r_t;
    logic signed [31:0] r_term;
    logic signed [31:0] r_acc;
    logic signed [31:0] r_q;
    logic signed [31:0] r_y;
    logic [INV_W-1:0]   r_inv;
    logic [OUT_W-1:0]   r_out;

    logic [RECIP_W-1:0] w_m;
    logic [40:0]        w_lq;
    logic [31:0]        w_tp;
    logic [31:0]        w_ymag;
    logic [43:0]        w_eq;
    logic [19:0]        w_qm;
    logic signed [63:0] w_ep;
    logic signed [49:0] w_sp;
    logic signed [37:0] w_fp;
    logic signed [21:0] w_v;
    logic [OUT_W-1:0]   w_clamp;
    logic [16:0]        w_x0;

    always_comb begin
        w_m    = recip(i_cmd.k);
        w_lq   = 41'(r_term[15:0]) * 41'(w_m);
        w_tp   = 32'(r_term[15:0]) * 32'(r_t);
        w_ymag = r_y[31] ? 32'(-r_y) : 32'(r_y);
        w_eq   = 44'(w_ymag[18:0]) * 44'(w_m);
        w_qm   = w_eq[43:24];
        w_ep   = 64'(r_term) * 64'(r_q);
        w_sp   = $signed({1'b0, r_inv}) * 50'(r_acc);
        w_fp   = 38'(r_acc) * 38'sd63;
        w_v    = w_fp[37:16];
        if (w_v < 0) begin
            w_clamp = '0;
        end else if (w_v > 22'sd63) begin
            w_clamp = OUT_MAX;
        end else begin
            w_clamp = w_v[OUT_W-1:0];
        end
        // 65536/255 = 257 + 1/255, so only full scale picks up the extra lsb
        w_x0 = 17'(17'd257 * 17'(i_pixel_level)) + 17'(i_pixel_level == PIXEL_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cfg_we) begin
            r_level <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_x   <= w_x0;
                r_acc <= '0;
                r_inv <= gamma_recip(r_level);
            end
            OP_DOUBLE: begin
                r_x   <= {r_x[15:0], 1'b0};
                r_acc <= r_acc - $signed(LN2_FX);
            end
            OP_LN_INIT: begin
                r_t    <= r_x[15:0];
                r_term <= {16'd0, r_x[15:0]};
            end
            OP_LN_DIV: begin
                r_q    <= {15'd0, w_lq[40:24]};
                r_term <= {16'd0, w_tp[31:16]};
            end
            OP_LN_ACC: begin
                r_acc <= i_cmd.k[0] ? r_acc + r_q : r_acc - r_q;
            end
            OP_SCALE_Y: begin
                r_y <= w_sp[47:16];
            end
            OP_EXP_INIT: begin
                r_acc  <= $signed(ONE_FX);
                r_term <= $signed(ONE_FX);
            end
            OP_EXP_DIV: begin
                r_q <= r_y[31] ? -$signed({12'd0, w_qm}) : $signed({12'd0, w_qm});
            end
            OP_EXP_MUL: begin
                r_term <= w_ep[47:16];
            end
            OP_EXP_ACC: begin
                r_acc <= r_acc + r_term;
            end
            OP_LOAD_OUT: begin
                r_out <= w_clamp;
            end
            default: begin
            end
        endcase
    end

    assign o_status.x_zero    = (r_x == '0);
    assign o_status.x_ge_one  = r_x[16];
    assign o_status.term_zero = (r_term == '0);
    assign o_corrected_level  = r_out;

endmodule

@@ rtl/core/gcfp_ctrl.sv @@
`timescale 1ns / 1ps
module gcfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  gcfp_pkg::t_status i_status,
    output gcfp_pkg::t_cmd    o_cmd
);
    import gcfp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_LN_INIT,
        S_LN_DIV,
        S_LN_ACC,
        S_SCALE,
        S_EXP_INIT,
        S_EXP_DIV,
        S_EXP_MUL,
        S_EXP_ACC,
        S_FINAL
    } t_state;

    t_state         r_state, n_state;
    logic [K_W-1:0] r_k, n_k;
    logic           r_out_valid, n_out_valid;
    t_op            w_op;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_out_valid = r_out_valid && !i_out_ready;
        w_op        = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_op    = OP_LOAD;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                priority if (i_status.x_zero) begin
                    n_state = S_FINAL;
                end else if (!i_status.x_ge_one) begin
                    w_op = OP_DOUBLE;
                end else begin
                    n_state = S_LN_INIT;
                end
            end
            S_LN_INIT: begin
                w_op    = OP_LN_INIT;
                n_k     = 5'd1;
                n_state = S_LN_DIV;
            end
            S_LN_DIV: begin
                w_op    = OP_LN_DIV;
                n_state = S_LN_ACC;
            end
            S_LN_ACC: begin
                w_op = OP_LN_ACC;
                if (r_k == SERIES_TERMS) begin
                    n_state = S_SCALE;
                end else begin
                    n_k     = r_k + 5'd1;
                    n_state = S_LN_DIV;
                end
            end
            S_SCALE: begin
                w_op    = OP_SCALE_Y;
                n_state = S_EXP_INIT;
            end
            S_EXP_INIT: begin
                w_op    = OP_EXP_INIT;
                n_k     = 5'd1;
                n_state = S_EXP_DIV;
            end
            S_EXP_DIV: begin
                w_op    = OP_EXP_DIV;
                n_state = S_EXP_MUL;
            end
            S_EXP_MUL: begin
                w_op    = OP_EXP_MUL;
                n_state = S_EXP_ACC;
            end
            S_EXP_ACC: begin
                w_op = OP_EXP_ACC;
                // series stops once a term underflows to zero or k reaches SERIES_TERMS
                if (i_status.term_zero || r_k == SERIES_TERMS) begin
                    n_state = S_FINAL;
                end else begin
                    n_k     = r_k + 5'd1;
                    n_state = S_EXP_DIV;
                end
            end
            S_FINAL: begin
                if (!r_out_valid || i_out_ready) begin
                    w_op        = OP_LOAD_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.op    = w_op;
    assign o_cmd.k     = r_k;

endmodule

@@ rtl/core/gamma_curve_fixed_point_top.sv @@
`timescale 1ns / 1ps
// Gamma curve, 16.16 fixed point.
// i_pix: valid/ready channel carrying an 8-bit pixel_level. o_cor: valid/ready
// channel returning the 6-bit corrected_level, one per input transfer.
// i_cfg_we/i_cfg_data write the 3-bit gamma level (0..4 = gamma 1.0..2.0,
// higher codes act as 4); write only while no pixel is in flight.
// Each pixel is computed on its own as exp(ln(x)/gamma) by a sequencer driving
// one datapath: up to 8 normalize steps, 20 ln terms (a divide and an accumulate
// step each), then 1 to 20 exp terms (a divide, a multiply and an accumulate step
// each). The time to a valid result is set by the normalize count and the two
// series loops; one item is worked at a time, and the next pixel is accepted in
// the cycle after the result is loaded.
// A zero pixel skips the series and goes from the normalize step to the final step.
// The result sits in an output register; a new pixel is accepted while it
// waits. If the receiver stalls, the next result holds in the final step
// until the output register frees up.
// Reset (synchronous, active low) clears the gamma level to 0 and drops
// any item in flight.
module gamma_curve_fixed_point_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gcfp_pixel_if.sink  i_pix,
    gcfp_level_if.source o_cor,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data
);
    import gcfp_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    gcfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_cor.valid),
        .i_out_ready (o_cor.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    gcfp_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_pixel_level     (i_pix.pixel_level),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_corrected_level (o_cor.corrected_level)
    );

endmodule

@@ bench/gcfp_tb_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces come from the RTL (gcfp_if.sv); nothing extra is needed here.
package gcfp_tb_pkg;
    localparam int unsigned PIX_LAST = 255;
endpackage

@@ bench/gamma_curve_fixed_point_top_tb.sv @@
`timescale 1ns / 1ps
module gamma_curve_fixed_point_top_tb;
    import gcfp_pkg::*;
    import gcfp_tb_pkg::*;

    localparam int N_RANDOM = 1930;
    localparam int LEVEL_CNT = 5;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [LEVEL_W-1:0] i_cfg_data;
    int errors = 0;

    gcfp_pixel_if pix ();
    gcfp_level_if cor ();

    gamma_curve_fixed_point_top dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (pix.sink),
        .o_cor     (cor.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // 16.16 helpers, 64-bit signed
    function automatic longint fl16(input longint v);
        return v >>> 16;
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        return fl16(a * b);
    endfunction

    function automatic longint fdiv(input longint a, input longint b);
        return (a * 65536) / b;
    endfunction

    function automatic longint fln(input longint x);
        longint acc, t, term, q;
        acc = 0;
        if (x <= 0) return 0;
        while (x > 65536) begin
            acc += 45426;
            x = fdiv(x, 131072);
        end
        while (x < 65536) begin
            acc -= 45426;
            x = fmul(x, 131072);
        end
        t = x - 65536;
        term = t;
        for (int k = 1; k <= 20; k++) begin
            q = fdiv(term, longint'(k) * 65536);
            if (k % 2 == 1) acc += q;
            else acc -= q;
            term = fmul(term, t);
        end
        return acc;
    endfunction

    function automatic longint fexp(input longint x);
        longint acc, term;
        acc = 65536;
        term = 65536;
        for (int k = 1; k <= 20; k++) begin
            term = fmul(term, fdiv(x, longint'(k) * 65536));
            acc += term;
            if (term == 0) break;
        end
        return acc;
    endfunction

    function automatic logic [OUT_W-1:0] corrected_of(input logic [LEVEL_W-1:0] lvl,
                                                      input logic [PIXEL_W-1:0] p);
        longint gam[LEVEL_CNT] = '{65536, 75366, 88474, 106168, 131072};
        longint inv, x, pw, v;
        int sel;
        sel = (lvl >= LEVEL_CNT) ? LEVEL_CNT - 1 : int'(lvl);
        inv = fdiv(65536, gam[sel]);
        x = fdiv(longint'(p) * 65536, longint'(255) * 65536);
        pw = (x <= 0) ? 0 : fexp(fmul(inv, fln(x)));
        v = fl16(fmul(longint'(63) * 65536, pw));
        if (v > 63) v = 63;
        else if (v < 0) v = 0;
        return v[OUT_W-1:0];
    endfunction

    class level_scoreboard;
        logic [LEVEL_W-1:0] gamma_sel;
        logic [OUT_W-1:0] pending[$];
        logic [PIXEL_W-1:0] pending_pix[$];
        int checked;

        function void note_pixel(input logic [PIXEL_W-1:0] p);
            pending.push_back(corrected_of(gamma_sel, p));
            pending_pix.push_back(p);
        endfunction

        task check_level(input logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            logic [PIXEL_W-1:0] p;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %0d", got));
                return;
            end
            want = pending.pop_front();
            p = pending_pix.pop_front();
            checked++;
            if (got !== want)
                report($sformatf("pixel %0d level %0d: got %0d want %0d",
                                 p, gamma_sel, got, want));
        endtask
    endclass

    level_scoreboard sb;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // receiver with random stalls, sampled at the edge
    bit stall_free = 0;
    initial begin
        int hold;
        cor.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (cor.valid && cor.ready) sb.check_level(cor.corrected_level);
            if (hold > 0) begin
                hold--;
                cor.ready <= 1'b0;
            end else begin
                cor.ready <= 1'b1;
                if (!stall_free && $urandom_range(0, 3) == 0) hold = gap_len();
            end
        end
    end

    bit no_gaps = 0;

    task automatic idle_input();
        pix.valid <= 1'b0;
    endtask

    // valid stays up after a transfer until the next call picks its gap
    task automatic send_pixel(input logic [PIXEL_W-1:0] p);
        int g;
        g = no_gaps ? 0 : gap_len();
        if (g > 0) begin
            pix.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.pixel_level <= p;
        do @(posedge i_clk); while (!pix.ready);
        sb.note_pixel(p);
    endtask

    task automatic drain();
        int guard = 0;
        idle_input();
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (150) @(posedge i_clk);
    endtask

    task automatic set_gamma(input logic [LEVEL_W-1:0] lvl);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= lvl;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.gamma_sel = lvl;
    endtask

    initial begin
        logic [LEVEL_W-1:0] lvls[10];
        int per;
        lvls = '{3'd0, 3'd4, 3'd1, 3'd7, 3'd2, 3'd5, 3'd3, 3'd6, 3'd0, 3'd4};
        sb = new();
        sb.gamma_sel = '0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        pix.valid <= 1'b0;
        pix.pixel_level <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and corners at reset gamma, then at 2.0
        foreach (lvls[i]) begin
            if (i == 2) break;
            if (i == 1) set_gamma(lvls[i]);
            send_pixel(8'd0);
            send_pixel(PIXEL_W'(PIX_LAST));
            send_pixel(8'd1);
            send_pixel(8'd254);
            send_pixel(8'd128);
            send_pixel(8'd127);
            send_pixel(8'h55);
            send_pixel(8'hAA);
        end
        // back-to-back burst with no sender gaps and no new receiver stalls
        no_gaps = 1;
        stall_free = 1;
        for (int i = 0; i < 6; i++) send_pixel(PIXEL_W'($urandom_range(0, PIX_LAST)));
        no_gaps = 0;
        stall_free = 0;

        per = N_RANDOM / 10;
        foreach (lvls[i]) begin
            set_gamma(lvls[i]);
            for (int n = 0; n < per; n++) begin
                send_pixel(PIXEL_W'($urandom_range(0, PIX_LAST)));
                // sender waits for all results once per phase
                if (n == per / 2) begin
                    idle_input();
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
            end
        end
        drain();
        $display("covered %0d results over all gamma codes 0..7, incl. zero and full-scale",
                 sb.checked);
        $display("with random sender gaps, receiver stalls and a back-to-back burst");
        if (errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/gcfp_pkg.sv
rtl/core/gcfp_if.sv
rtl/core/gcfp_datapath.sv
rtl/core/gcfp_ctrl.sv
rtl/core/gamma_curve_fixed_point_top.sv
bench/gcfp_tb_if.sv
bench/gamma_curve_fixed_point_top_tb.sv
